/* rtl/core/ack_packet_matcher_defines.svh */
// Assertion macros used by the checker file of the acknowledge matcher.
`ifndef ACK_PACKET_MATCHER_DEFINES_SVH
`define ACK_PACKET_MATCHER_DEFINES_SVH

// Checked on every rising clock edge outside of reset.
`define AMP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, including during reset.
`define AMP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/amp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package amp_pkg;

   localparam int unsigned CommandWidth = 2;
   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned StatusWidth  = 2;
   localparam int unsigned IndexWidth   = 4;
   localparam int unsigned TicksWidth   = 16;
   localparam int unsigned ElapsedWidth = TicksWidth + 1;
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   typedef logic [IndexWidth-1:0]   index_type;
   typedef logic [ByteWidth-1:0]    byte_type;
   typedef logic [TicksWidth-1:0]   ticks_type;
   typedef logic [ElapsedWidth-1:0] elapsed_type;

   typedef enum logic [CommandWidth-1:0] {
      CMD_START = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_IDLE    = 2'd0,
      STATUS_WAITING = 2'd1,
      STATUS_ACKED   = 2'd2,
      STATUS_TIMEOUT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_CLASS   = 2'd0,
      REG_ID      = 2'd1,
      REG_TIMEOUT = 2'd2
   } reg_index_type;

   localparam ticks_type TimeoutReset = 16'd3000;

   localparam index_type PktLen   = 4'd10;
   localparam index_type IdxClass = 4'd6;
   localparam index_type IdxId    = 4'd7;
   localparam index_type IdxChkA  = 4'd8;

   localparam byte_type HeadBytes [0:5] = '{8'hB5, 8'h62, 8'h05, 8'h01, 8'h02, 8'h00};

   typedef struct packed {
      byte_type  expected_class;
      byte_type  expected_id;
      ticks_type timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [CommandWidth-1:0] command;
      byte_type                rx_byte;
   } req_item_type;

   // Fletcher sum over packet bytes 2 to 7, returned as {check_b, check_a}.
   function automatic logic [2*ByteWidth-1:0] fletcher_pair(byte_type cls, byte_type id);
      byte_type sum_a;
      byte_type sum_b;
      byte_type bytes [0:5];
      bytes[0] = HeadBytes[2];
      bytes[1] = HeadBytes[3];
      bytes[2] = HeadBytes[4];
      bytes[3] = HeadBytes[5];
      bytes[4] = cls;
      bytes[5] = id;
      sum_a = '0;
      sum_b = '0;
      for (int k = 0; k < 6; k++) begin
         sum_a = sum_a + bytes[k];
         sum_b = sum_b + sum_a;
      end
      return {sum_b, sum_a};
   endfunction

endpackage

`default_nettype wire

/* rtl/core/amp_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface amp_req_if import amp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CommandWidth-1:0] command;
   logic [ByteWidth-1:0]    rx_byte;

   modport source (output valid, output command, output rx_byte, input ready);
   modport sink (input valid, input command, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/amp_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface amp_rsp_if import amp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [StatusWidth-1:0] status;
   logic [IndexWidth-1:0]  matched_count;

   modport source (output valid, output status, output matched_count, input ready);
   modport sink (input valid, input status, input matched_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/ack_packet_matcher.sv */
// Path: a request is accepted into the input register, and its result is then registered in
// the response register that drives the response port.
// Throughput: one request per cycle while the response side is ready; a stalled response
// holds the input register, so at most one request waits behind it.
// Reset: synchronous and active high; it clears the match state and empties both registers,
// and it sets class and id to zero and the timeout to 3000 ticks.
`timescale 1ns / 1ps
`default_nettype none

module ack_packet_matcher import amp_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   amp_req_if.sink                      req_chan,
   amp_rsp_if.source                    rsp_chan,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [CsrDataWidth-1:0] csr_pwdata,
   output logic      [CsrDataWidth-1:0] csr_prdata,
   output logic                         csr_pready
);

   cfg_type      cfg;
   logic         item_valid;
   req_item_type item;
   logic         item_take;

   amp_csr u_amp_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   amp_in_stage u_amp_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   amp_match u_amp_match (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .cfg        (cfg),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

/* rtl/core/amp_csr.sv */
`timescale 1ns / 1ps
`default_nettype none

module amp_csr import amp_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [CsrDataWidth-1:0] csr_pwdata,
   output logic      [CsrDataWidth-1:0] csr_prdata,
   output logic                         csr_pready,
   output cfg_type                      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_paddr[3:2])
            REG_CLASS: begin
               cfg_in.expected_class = csr_pwdata[ByteWidth-1:0];
            end
            REG_ID: begin
               cfg_in.expected_id = csr_pwdata[ByteWidth-1:0];
            end
            REG_TIMEOUT: begin
               cfg_in.timeout_ticks = csr_pwdata[TicksWidth-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_class <= '0;
         cfg_ff.expected_id    <= '0;
         cfg_ff.timeout_ticks  <= TimeoutReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_CLASS: begin
            csr_prdata = {{(CsrDataWidth-ByteWidth){1'b0}}, cfg_ff.expected_class};
         end
         REG_ID: begin
            csr_prdata = {{(CsrDataWidth-ByteWidth){1'b0}}, cfg_ff.expected_id};
         end
         REG_TIMEOUT: begin
            csr_prdata = {{(CsrDataWidth-TicksWidth){1'b0}}, cfg_ff.timeout_ticks};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/core/amp_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module amp_in_stage import amp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   amp_req_if.sink      req_chan,
   output logic         item_valid,
   output req_item_type item,
   input  wire logic    item_take
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   req_item_type item_in;
   logic         accept;

   assign req_chan.ready = !valid_ff || item_take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in        = 1'b1;
         item_in.command = req_chan.command;
         item_in.rx_byte = req_chan.rx_byte;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

/* rtl/core/amp_match.sv */
`timescale 1ns / 1ps
`default_nettype none

module amp_match import amp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    item_valid,
   input  req_item_type item,
   output logic         item_take,
   input  cfg_type      cfg,
   amp_rsp_if.source    rsp_chan
);

   logic        waiting_ff;
   logic        waiting_in;
   index_type   match_index_ff;
   index_type   match_index_in;
   elapsed_type elapsed_ticks_ff;
   elapsed_type elapsed_ticks_in;
   byte_type    check_a_ff;
   byte_type    check_a_in;
   byte_type    check_b_ff;
   byte_type    check_b_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   status_type  status_ff;
   status_type  status_in;
   index_type   count_ff;
   byte_type    expected_byte;

   assign item_take = item_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      case (match_index_ff) inside
         [4'd0:4'd5]: begin
            expected_byte = HeadBytes[match_index_ff[2:0]];
         end
         IdxClass: begin
            expected_byte = cfg.expected_class;
         end
         IdxId: begin
            expected_byte = cfg.expected_id;
         end
         IdxChkA: begin
            expected_byte = check_a_ff;
         end
         default: begin
            expected_byte = check_b_ff;
         end
      endcase
   end

   always_comb begin
      waiting_in       = waiting_ff;
      match_index_in   = match_index_ff;
      elapsed_ticks_in = elapsed_ticks_ff;
      check_a_in       = check_a_ff;
      check_b_in       = check_b_ff;
      if (item_take) begin
         case (item.command)
            CMD_START: begin
               {check_b_in, check_a_in} = fletcher_pair(cfg.expected_class, cfg.expected_id);
               match_index_in   = '0;
               elapsed_ticks_in = '0;
               waiting_in       = 1'b1;
            end
            CMD_BYTE: begin
               if (waiting_ff) begin
                  if ((match_index_ff < PktLen) && (item.rx_byte == expected_byte)) begin
                     match_index_in = match_index_ff + 4'd1;
                  end else begin
                     match_index_in = '0;
                  end
                  if (match_index_in >= PktLen) begin
                     waiting_in = 1'b0;
                  end
               end
            end
            CMD_TICK: begin
               if (waiting_ff) begin
                  elapsed_ticks_in = elapsed_ticks_ff + 17'd1;
                  if (elapsed_ticks_in > {1'b0, cfg.timeout_ticks}) begin
                     waiting_in = 1'b0;
                  end
               end
            end
            default: begin
               waiting_in = waiting_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (waiting_in) begin
         status_in = STATUS_WAITING;
      end else if (match_index_in >= PktLen) begin
         status_in = STATUS_ACKED;
      end else if (elapsed_ticks_in != '0) begin
         status_in = STATUS_TIMEOUT;
      end else begin
         status_in = STATUS_IDLE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff       <= 1'b0;
         match_index_ff   <= '0;
         elapsed_ticks_ff <= '0;
         check_a_ff       <= '0;
         check_b_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         waiting_ff       <= waiting_in;
         match_index_ff   <= match_index_in;
         elapsed_ticks_ff <= elapsed_ticks_in;
         check_a_ff       <= check_a_in;
         check_b_ff       <= check_b_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         status_ff <= status_in;
         count_ff  <= match_index_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.matched_count = count_ff;

endmodule

`default_nettype wire

/* rtl/core/amp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "ack_packet_matcher_defines.svh"

module amp_checker import amp_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   amp_rsp_if.source rsp_chan
);

   `AMP_ASSERT(a_rsp_hold, clock, reset, rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(rsp_chan.status) && $stable(rsp_chan.matched_count), "Stalled response changed.")
   `AMP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_chan.valid, "Response valid right after reset.")
   `AMP_ASSERT(a_count_range, clock, reset, rsp_chan.valid |-> rsp_chan.matched_count <= PktLen, "Matched count beyond packet length.")
   `AMP_ASSERT(a_acked_full, clock, reset, rsp_chan.valid && (rsp_chan.status == STATUS_ACKED) |-> rsp_chan.matched_count == PktLen, "Acknowledged without a full packet.")
   `AMP_ASSERT(a_idle_empty, clock, reset, rsp_chan.valid && (rsp_chan.status == STATUS_IDLE) |-> rsp_chan.matched_count == '0, "Idle with a partial match.")

endmodule

bind ack_packet_matcher amp_checker u_amp_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_chan (rsp_chan)
);

`default_nettype wire
